// ===== hw/rtl/oli_pkg.sv =====
// ----------------------------------------------------------------------------
// oli_pkg
// Shared widths, request and status codes, and controller states for the
// ordered list block.
// ----------------------------------------------------------------------------
package oli_pkg;

  // Default sizing of the list
  localparam int CAPACITY_DEF   = 16;
  localparam int WORD_WIDTH_DEF = 32;

  // Fixed port field widths
  localparam int REQ_W      = 3;
  localparam int POS_W      = 8;
  localparam int IN_WORD_W  = 32;
  localparam int OUT_WORD_W = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_GET    = 3'd2,
    REQ_SET    = 3'd3,
    REQ_PUSH   = 3'd4,
    REQ_POP    = 3'd5,
    REQ_LAST   = 3'd6
  } oli_req_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } oli_status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PUT,
    S_DONE
  } oli_state_t;

endpackage

// ===== hw/rtl/oli_ram.sv =====
// ----------------------------------------------------------------------------
// oli_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module oli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/ordered_list_insert_remove.sv =====
// ----------------------------------------------------------------------------
// ordered_list_insert_remove
// Fixed-capacity ordered list of words held in one RAM.
// ----------------------------------------------------------------------------
// Usage: one request enters on the in_ channel (valid/stall) and exactly one
// result leaves on the out_ channel: a status, the word read or removed
// (zero when refused and for insert, set and push) and the length after the
// request. Requests are handled one at a time; in_stall is high while a
// request is in progress or its result is still waiting to be loaded.
// Refusals, set, push and insert at the end load the result directly; get
// and last first read the entry. Insert at position p first moves the
// entries from the end down to p up by one and then writes the new word;
// remove at p reads the entry and then moves the entries above it down. The
// single RAM write port moves one entry per cycle during the shift.
// Reset empties the list at once (length zero, no clearing pass); RAM
// contents are not cleared and are never read before being written.
// When the receiver stalls, the result is held in the output register and
// the controller waits before loading the next one.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove
  import oli_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [POS_W-1:0]      in_position,
  input  logic [IN_WORD_W-1:0]  in_word_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [OUT_WORD_W-1:0] out_word_out,
  output logic [COUNT_W-1:0]    out_count
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int FW    = $clog2(CAPACITY + 1);
  localparam int CMP_W = (FW > POS_W) ? FW : POS_W;
  localparam int WPAD  = (WORD_WIDTH > IN_WORD_W) ? WORD_WIDTH : IN_WORD_W;
  localparam int CPAD  = (FW > COUNT_W) ? FW : COUNT_W;

  oli_state_t            state_r, state_nxt;
  logic [FW-1:0]         fill_r, fill_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [WORD_WIDTH-1:0] word_r, word_nxt;
  logic [WORD_WIDTH-1:0] res_word_r, res_word_nxt;
  oli_status_t           status_r, status_nxt;
  logic                  is_rm_r, is_rm_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [OUT_WORD_W-1:0] out_word_r, out_word_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [WORD_WIDTH-1:0] ram_rdata;

  logic [WPAD-1:0]       win_pad;
  logic [WORD_WIDTH-1:0] win_trim;
  logic [WPAD-1:0]       wout_pad;
  logic [CPAD-1:0]       fill_pad;
  logic [CMP_W-1:0]      fill_ext;
  logic [CMP_W-1:0]      epos;
  logic [AW-1:0]         eaddr;
  logic [AW-1:0]         last_addr;
  logic                  accept;
  logic                  out_free;

  // Width adaptation of words and count
  assign win_pad  = WPAD'(in_word_in);
  assign win_trim = win_pad[WORD_WIDTH-1:0];
  assign wout_pad = WPAD'(res_word_r);
  assign fill_pad = CPAD'(fill_r);
  assign fill_ext = CMP_W'(fill_r);
  assign last_addr = fill_r[AW-1:0];

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Effective position of the transaction
  always_comb begin
    case (in_req_type)
      REQ_PUSH:           epos = fill_ext;
      REQ_POP, REQ_LAST:  epos = fill_ext - CMP_W'(1);
      default:            epos = CMP_W'(in_position);
    endcase
  end
  assign eaddr = epos[AW-1:0];

  // Next state, RAM control and result staging
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    ptr_nxt        = ptr_r;
    pos_nxt        = pos_r;
    word_nxt       = word_r;
    res_word_nxt   = res_word_r;
    status_nxt     = status_r;
    is_rm_nxt      = is_rm_r;
    ram_we         = 1'b0;
    ram_waddr      = ptr_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = ptr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_word_nxt   = out_word_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pos_nxt      = eaddr;
          word_nxt     = win_trim;
          res_word_nxt = '0;
          is_rm_nxt    = 1'b0;
          status_nxt   = ST_RANGE;
          state_nxt    = S_DONE;
          case (in_req_type)
            REQ_INSERT, REQ_PUSH: begin
              if (epos > fill_ext) begin
                status_nxt = ST_RANGE;
              end else if (fill_r == FW'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                status_nxt = ST_DONE;
                fill_nxt   = fill_r + FW'(1);
                if (epos == fill_ext) begin
                  // Append: write in place
                  ram_we    = 1'b1;
                  ram_waddr = eaddr;
                  ram_wdata = win_trim;
                end else begin
                  // Start moving the tail up from the last entry
                  ram_raddr = last_addr - AW'(1);
                  ptr_nxt   = last_addr - AW'(1);
                  state_nxt = S_SHIFT_UP;
                end
              end
            end
            REQ_REMOVE, REQ_POP: begin
              if (epos < fill_ext) begin
                status_nxt = ST_DONE;
                fill_nxt   = fill_r - FW'(1);
                is_rm_nxt  = 1'b1;
                ram_raddr  = eaddr;
                ptr_nxt    = eaddr;
                state_nxt  = S_READ;
              end
            end
            REQ_GET, REQ_LAST: begin
              if (epos < fill_ext) begin
                status_nxt = ST_DONE;
                ram_raddr  = eaddr;
                ptr_nxt    = eaddr;
                state_nxt  = S_READ;
              end
            end
            REQ_SET: begin
              if (epos < fill_ext) begin
                status_nxt = ST_DONE;
                ram_we     = 1'b1;
                ram_waddr  = eaddr;
                ram_wdata  = win_trim;
              end
            end
            default: begin
              status_nxt = ST_RANGE;
            end
          endcase
        end
      end

      S_READ: begin
        // Capture the addressed entry; a remove then pulls the tail down
        res_word_nxt = ram_rdata;
        if (is_rm_r && (ptr_r != last_addr)) begin
          ram_raddr = ptr_r + AW'(1);
          ptr_nxt   = ptr_r + AW'(1);
          state_nxt = S_SHIFT_DN;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SHIFT_UP: begin
        // Move entry ptr to ptr+1, read the one below
        ram_we    = 1'b1;
        ram_waddr = ptr_r + AW'(1);
        ram_wdata = ram_rdata;
        if (ptr_r == pos_r) begin
          state_nxt = S_PUT;
        end else begin
          ram_raddr = ptr_r - AW'(1);
          ptr_nxt   = ptr_r - AW'(1);
        end
      end

      S_SHIFT_DN: begin
        // Move entry ptr to ptr-1, read the one above
        ram_we    = 1'b1;
        ram_waddr = ptr_r - AW'(1);
        ram_wdata = ram_rdata;
        if (ptr_r == last_addr) begin
          state_nxt = S_DONE;
        end else begin
          ram_raddr = ptr_r + AW'(1);
          ptr_nxt   = ptr_r + AW'(1);
        end
      end

      S_PUT: begin
        // Drop the new word into the opened slot
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = word_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Load the result once the output register is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_word_nxt   = (status_r == ST_DONE) ? wout_pad[OUT_WORD_W-1:0] : '0;
          out_count_nxt  = fill_pad[COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    pos_r        <= pos_nxt;
    word_r       <= word_nxt;
    res_word_r   <= res_word_nxt;
    status_r     <= status_nxt;
    is_rm_r      <= is_rm_nxt;
    out_status_r <= out_status_nxt;
    out_word_r   <= out_word_nxt;
    out_count_r  <= out_count_nxt;
  end

  // Entry storage
  oli_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_word_out = out_word_r;
  assign out_count    = out_count_r;

endmodule
